@@ src/blem_pkg.sv @@
`timescale 1ns / 1ps

package blem_pkg;

  localparam int TimeW  = 32;
  localparam int CodeW  = 10;
  localparam int CountW = 16;
  localparam int CmdW   = 2;
  localparam int RegIdxW = 3;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_START = 2'd1;
  localparam logic [CmdW-1:0] CMD_ABORT = 2'd2;

  localparam logic [RegIdxW-1:0] REG_LOW_THRESHOLD   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HIGH_THRESHOLD  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_BLUE_ABOVE_RED  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_HALF_PERIOD_US  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_EDGE_TIMEOUT_US = 3'd4;
  localparam logic [RegIdxW-1:0] REG_SESSION_US      = 3'd5;

  localparam logic [TimeW-1:0]  ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_ABORT,
    KIND_NOP
  } kind_t;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_BLUE = 2'd1,
    WAIT_RED  = 2'd2
  } wait_t;

  typedef struct packed {
    logic [CodeW-1:0] low_threshold;
    logic [CodeW-1:0] high_threshold;
    logic             blue_above_red;
    logic [TimeW-1:0] half_period_us;
    logic [TimeW-1:0] edge_timeout_us;
    logic [TimeW-1:0] session_us;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [TimeW-1:0] now_us;
    logic             above_high;
    logic             below_low;
  } item_t;

  typedef struct packed {
    logic              active;
    logic              led_blue;
    logic              session_done;
    logic              captured;
    logic [TimeW-1:0]  delta_us;
    logic [CountW-1:0] count_red_to_blue;
    logic [CountW-1:0] count_blue_to_red;
    logic [CountW-1:0] lost_count;
    logic [TimeW-1:0]  min_us;
    logic [TimeW-1:0]  max_us;
    logic [TimeW-1:0]  sum_red_to_blue_us;
    logic [TimeW-1:0]  sum_blue_to_red_us;
  } result_t;

endpackage

@@ src/blem_if.sv @@
`timescale 1ns / 1ps

interface blem_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now_us;
  logic [9:0]  light_code;

  modport source (output valid, output cmd, output now_us, output light_code, input ready);
  modport sink (input valid, input cmd, input now_us, input light_code, output ready);
endinterface

interface blem_out_if;
  logic        valid;
  logic        ready;
  logic        active;
  logic        led_blue;
  logic        session_done;
  logic        captured;
  logic [31:0] delta_us;
  logic [15:0] count_red_to_blue;
  logic [15:0] count_blue_to_red;
  logic [15:0] lost_count;
  logic [31:0] min_us;
  logic [31:0] max_us;
  logic [31:0] sum_red_to_blue_us;
  logic [31:0] sum_blue_to_red_us;

  modport source (
    output valid, input ready,
    output active, output led_blue, output session_done, output captured, output delta_us,
    output count_red_to_blue, output count_blue_to_red, output lost_count,
    output min_us, output max_us, output sum_red_to_blue_us, output sum_blue_to_red_us
  );
  modport sink (
    input valid, output ready,
    input active, input led_blue, input session_done, input captured, input delta_us,
    input count_red_to_blue, input count_blue_to_red, input lost_count,
    input min_us, input max_us, input sum_red_to_blue_us, input sum_blue_to_red_us
  );
endinterface

@@ src/blink_edge_latency_meter_core.sv @@
`timescale 1ns / 1ps

// Blink edge latency meter. Each input transaction is a tick, start or abort with a
// microsecond timestamp and a light sample (any other command is a no-op); each one
// yields exactly one result transaction with the session status and the latency
// statistics after it. The block sustains one transaction per clock cycle while the
// output channel takes results: the front decodes the command and compares the sample
// with both thresholds, a small queue of QueueDepth entries follows, and the back
// updates the state and statistics and holds the result in an output register. The user
// must write registers via cfg_we, cfg_index and cfg_data only while idle (unchecked).
module blink_edge_latency_meter_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  blem_in_if.sink     in_ch,
  blem_out_if.source  out_ch
);

  blem_pkg::cfg_t  cfg;
  blem_pkg::item_t front_item;
  blem_pkg::item_t back_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold   <= 10'd400;
      cfg.high_threshold  <= 10'd600;
      cfg.blue_above_red  <= 1'b1;
      cfg.half_period_us  <= 32'd250000;
      cfg.edge_timeout_us <= 32'd200000;
      cfg.session_us      <= 32'd30000000;
    end else if (cfg_we) begin
      case (cfg_index)
        blem_pkg::REG_LOW_THRESHOLD:   cfg.low_threshold   <= cfg_data[9:0];
        blem_pkg::REG_HIGH_THRESHOLD:  cfg.high_threshold  <= cfg_data[9:0];
        blem_pkg::REG_BLUE_ABOVE_RED:  cfg.blue_above_red  <= cfg_data[0];
        blem_pkg::REG_HALF_PERIOD_US:  cfg.half_period_us  <= cfg_data;
        blem_pkg::REG_EDGE_TIMEOUT_US: cfg.edge_timeout_us <= cfg_data;
        blem_pkg::REG_SESSION_US:      cfg.session_us      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  blem_front u_front (
    .in_ch (in_ch),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .item  (front_item)
  );

  blem_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (front_item),
    .full     (full),
    .pop      (pop),
    .item_out (back_item),
    .empty    (empty)
  );

  blem_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (back_item),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ src/blem_front.sv @@
`timescale 1ns / 1ps

module blem_front (
  blem_in_if.sink        in_ch,
  input  blem_pkg::cfg_t cfg,
  input  logic           full,
  output logic           push,
  output blem_pkg::item_t item
);

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // The threshold compares do not depend on block state, so they are done here.
  always_comb begin
    unique case (in_ch.cmd)
      blem_pkg::CMD_TICK:  item.kind = blem_pkg::KIND_TICK;
      blem_pkg::CMD_START: item.kind = blem_pkg::KIND_START;
      blem_pkg::CMD_ABORT: item.kind = blem_pkg::KIND_ABORT;
      default:             item.kind = blem_pkg::KIND_NOP;
    endcase
    item.now_us     = in_ch.now_us;
    item.above_high = in_ch.light_code > cfg.high_threshold;
    item.below_low  = in_ch.light_code < cfg.low_threshold;
  end

endmodule

@@ src/blem_queue.sv @@
`timescale 1ns / 1ps

module blem_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  blem_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output blem_pkg::item_t item_out,
  output logic            empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  blem_pkg::item_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == FullCnt);
  assign empty    = (count == '0);
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/blem_back.sv @@
`timescale 1ns / 1ps

module blem_back (
  input  logic            clk,
  input  logic            rst,
  input  blem_pkg::cfg_t  cfg,
  input  blem_pkg::item_t item,
  input  logic            empty,
  output logic            pop,
  blem_out_if.source      out_ch
);

  logic                                running, running_next;
  logic                                color_blue, color_blue_next;
  blem_pkg::wait_t                     wait_kind, wait_kind_next;
  logic [blem_pkg::TimeW-1:0]          start_time, start_time_next;
  logic [blem_pkg::TimeW-1:0]          toggle_time, toggle_time_next;
  logic [blem_pkg::TimeW-1:0]          edge_time, edge_time_next;
  logic [blem_pkg::CountW-1:0]         cnt_rb, cnt_rb_next;
  logic [blem_pkg::CountW-1:0]         cnt_br, cnt_br_next;
  logic [blem_pkg::TimeW-1:0]          sum_rb, sum_rb_next;
  logic [blem_pkg::TimeW-1:0]          sum_br, sum_br_next;
  logic [blem_pkg::TimeW-1:0]          min_all, min_all_next;
  logic [blem_pkg::TimeW-1:0]          max_all, max_all_next;
  logic [blem_pkg::CountW-1:0]         lost_total, lost_total_next;
  logic                                out_valid;
  blem_pkg::result_t                   res, res_next;

  logic                                take;
  logic [blem_pkg::TimeW-1:0]          sess_elapsed;
  logic [blem_pkg::TimeW-1:0]          tog_elapsed;
  logic [blem_pkg::TimeW-1:0]          delta;
  logic                                to_blue;
  logic                                rising;
  logic                                crossed;
  logic                                done;
  logic                                cap;
  logic                                any_rec;

  assign take = !empty && (!out_valid || out_ch.ready);
  assign pop  = take;

  assign sess_elapsed = item.now_us - start_time;
  assign tog_elapsed  = item.now_us - toggle_time;
  assign delta        = item.now_us - edge_time;
  assign to_blue      = (wait_kind == blem_pkg::WAIT_BLUE);
  assign rising       = cfg.blue_above_red ? to_blue : !to_blue;
  assign crossed      = rising ? item.above_high : item.below_low;

  always_comb begin
    running_next     = running;
    color_blue_next  = color_blue;
    wait_kind_next   = wait_kind;
    start_time_next  = start_time;
    toggle_time_next = toggle_time;
    edge_time_next   = edge_time;
    cnt_rb_next      = cnt_rb;
    cnt_br_next      = cnt_br;
    sum_rb_next      = sum_rb;
    sum_br_next      = sum_br;
    min_all_next     = min_all;
    max_all_next     = max_all;
    lost_total_next  = lost_total;
    done             = 1'b0;
    cap              = 1'b0;

    unique case (item.kind)
      blem_pkg::KIND_START: begin
        running_next     = 1'b1;
        color_blue_next  = 1'b0;
        wait_kind_next   = blem_pkg::WAIT_NONE;
        start_time_next  = item.now_us;
        toggle_time_next = item.now_us;
        cnt_rb_next      = '0;
        cnt_br_next      = '0;
        sum_rb_next      = '0;
        sum_br_next      = '0;
        min_all_next     = blem_pkg::ALL_ONES;
        max_all_next     = '0;
        lost_total_next  = '0;
      end
      blem_pkg::KIND_ABORT: begin
        running_next   = 1'b0;
        wait_kind_next = blem_pkg::WAIT_NONE;
      end
      blem_pkg::KIND_TICK: begin
        if (running) begin
          if (sess_elapsed >= cfg.session_us) begin
            running_next   = 1'b0;
            wait_kind_next = blem_pkg::WAIT_NONE;
            done           = 1'b1;
          end else begin
            if (wait_kind != blem_pkg::WAIT_NONE) begin
              if (crossed) begin
                cap            = 1'b1;
                wait_kind_next = blem_pkg::WAIT_NONE;
                if (to_blue) begin
                  if (cnt_rb != blem_pkg::COUNT_MAX) begin
                    cnt_rb_next = cnt_rb + 1'b1;
                  end
                  sum_rb_next = sum_rb + delta;
                end else begin
                  if (cnt_br != blem_pkg::COUNT_MAX) begin
                    cnt_br_next = cnt_br + 1'b1;
                  end
                  sum_br_next = sum_br + delta;
                end
                if (delta < min_all) begin
                  min_all_next = delta;
                end
                if (delta > max_all) begin
                  max_all_next = delta;
                end
              end else if (delta > cfg.edge_timeout_us) begin
                wait_kind_next = blem_pkg::WAIT_NONE;
                if (lost_total != blem_pkg::COUNT_MAX) begin
                  lost_total_next = lost_total + 1'b1;
                end
              end
            end
            if (tog_elapsed >= cfg.half_period_us) begin
              toggle_time_next = item.now_us;
              edge_time_next   = item.now_us;
              color_blue_next  = !color_blue;
              wait_kind_next   = color_blue ? blem_pkg::WAIT_RED : blem_pkg::WAIT_BLUE;
            end
          end
        end
      end
      blem_pkg::KIND_NOP: begin
      end
      default: begin
      end
    endcase

    any_rec = (cnt_rb_next != '0) || (cnt_br_next != '0);

    res_next.active             = running_next;
    res_next.led_blue           = running_next && color_blue_next;
    res_next.session_done       = done;
    res_next.captured           = cap;
    res_next.delta_us           = cap ? delta : '0;
    res_next.count_red_to_blue  = cnt_rb_next;
    res_next.count_blue_to_red  = cnt_br_next;
    res_next.lost_count         = lost_total_next;
    res_next.min_us             = any_rec ? min_all_next : '0;
    res_next.max_us             = any_rec ? max_all_next : '0;
    res_next.sum_red_to_blue_us = sum_rb_next;
    res_next.sum_blue_to_red_us = sum_br_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      color_blue  <= 1'b0;
      wait_kind   <= blem_pkg::WAIT_NONE;
      start_time  <= '0;
      toggle_time <= '0;
      edge_time   <= '0;
      cnt_rb      <= '0;
      cnt_br      <= '0;
      sum_rb      <= '0;
      sum_br      <= '0;
      min_all     <= blem_pkg::ALL_ONES;
      max_all     <= '0;
      lost_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        running     <= running_next;
        color_blue  <= color_blue_next;
        wait_kind   <= wait_kind_next;
        start_time  <= start_time_next;
        toggle_time <= toggle_time_next;
        edge_time   <= edge_time_next;
        cnt_rb      <= cnt_rb_next;
        cnt_br      <= cnt_br_next;
        sum_rb      <= sum_rb_next;
        sum_br      <= sum_br_next;
        min_all     <= min_all_next;
        max_all     <= max_all_next;
        lost_total  <= lost_total_next;
      end
      out_valid <= take || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.active             = res.active;
  assign out_ch.led_blue           = res.led_blue;
  assign out_ch.session_done       = res.session_done;
  assign out_ch.captured           = res.captured;
  assign out_ch.delta_us           = res.delta_us;
  assign out_ch.count_red_to_blue  = res.count_red_to_blue;
  assign out_ch.count_blue_to_red  = res.count_blue_to_red;
  assign out_ch.lost_count         = res.lost_count;
  assign out_ch.min_us             = res.min_us;
  assign out_ch.max_us             = res.max_us;
  assign out_ch.sum_red_to_blue_us = res.sum_red_to_blue_us;
  assign out_ch.sum_blue_to_red_us = res.sum_blue_to_red_us;

endmodule
